@@ hdl/modular_square_root_assert.svh @@
// Assertion macros for the modular square root block.
`ifndef MODULAR_SQUARE_ROOT_ASSERT_SVH
`define MODULAR_SQUARE_ROOT_ASSERT_SVH
`ifndef ASSERT_OFF
`define MSR_ASSERT_IMPL(label, ant, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("assertion failed");
`define MSR_ASSERT_NEXT(label, ant, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("assertion failed");
`else
`define MSR_ASSERT_IMPL(label, ant, cons)
`define MSR_ASSERT_NEXT(label, ant, cons)
`endif
`endif

@@ hdl/msr_pkg.sv @@
// ---------------------------------------------------------------------------
// msr_pkg
// Shared types for the modular square root block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package msr_pkg;
    localparam int unsigned NR_LIMIT = 1024;

    // Request to the bit-serial modular multiplier and remainder unit.
    typedef struct packed {
        logic start;
    } mul_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_sts_t;
endpackage
`default_nettype wire

@@ hdl/msr_mulmod.sv @@
// ---------------------------------------------------------------------------
// msr_mulmod
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module msr_mulmod
    import msr_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mul_ctl_t         ctl,
    output mul_sts_t              sts,
    input  wire logic [WIDTH-1:0] a,
    input  wire logic [WIDTH-1:0] b,
    input  wire logic [WIDTH-1:0] m,
    output logic      [WIDTH-1:0] prod
);
    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] acc_reg, acc_next;
    logic [WIDTH-1:0] sh_reg, sh_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WIDTH:0]   dbl;
    logic [WIDTH:0]   dbl_red;
    logic [WIDTH:0]   add;
    logic [WIDTH-1:0] step;

    always_comb
    begin
        // double, reduce, conditionally add a, reduce
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
        add     = dbl_red + {1'b0, a};
        if (sh_reg[WIDTH-1])
            step = (add >= {1'b0, m}) ? WIDTH'(add - {1'b0, m}) : WIDTH'(add);
        else
            step = WIDTH'(dbl_red);

        acc_next  = acc_reg;
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            acc_next  = '0;
            sh_next   = b;
            cnt_next  = CW'(WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = step;
            sh_next  = {sh_reg[WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign prod     = acc_reg;
endmodule
`default_nettype wire

@@ hdl/msr_divmod.sv @@
// ---------------------------------------------------------------------------
// msr_divmod
// Restoring remainder unit: one dividend bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module msr_divmod
    import msr_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mul_ctl_t         ctl,
    output mul_sts_t              sts,
    input  wire logic [WIDTH-1:0] num,
    input  wire logic [WIDTH-1:0] m,
    output logic      [WIDTH-1:0] rem
);
    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_reg, r_next;
    logic [WIDTH-1:0] sh_reg, sh_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [WIDTH:0]   trial;

    always_comb
    begin
        trial     = {r_reg, sh_reg[WIDTH-1]};
        r_next    = r_reg;
        sh_next   = sh_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            r_next    = '0;
            sh_next   = num;
            cnt_next  = CW'(WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            r_next   = (trial >= {1'b0, m}) ? WIDTH'(trial - {1'b0, m}) : WIDTH'(trial);
            sh_next  = {sh_reg[WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg  <= r_next;
        sh_reg <= sh_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign rem      = r_reg;
endmodule
`default_nettype wire

@@ hdl/modular_square_root.sv @@
// ---------------------------------------------------------------------------
// modular_square_root
// Tonelli-Shanks square root modulo a prime, built on a bit-serial multiplier.
// ---------------------------------------------------------------------------
// One transaction in, one transaction out. The value is reduced by a
// bit-serial remainder unit, then every modular product goes through one
// shared bit-serial multiplier. The Euler test and each non-residue test
// are about 2*WIDTH products, the three setup exponentiations about
// 6*WIDTH, and the correction loop up to s*s products where p-1 = q*2^s,
// so large s or a distant non-residue makes a transaction longer. The input
// is taken only while the block is idle; the result sits in an output
// register until taken. Primality is assumed, not checked.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "modular_square_root_assert.svh"
module modular_square_root
    import msr_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [31:0]      value,
    input  wire logic [31:0]      prime_modulus,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [31:0]      root,
    output logic                  no_root
);
    localparam int SW = $clog2(WIDTH + 1);
    localparam int NW = 11;

    // main sequencer, one-hot
    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_RED    = 14'b00000000000010,
        S_CHECK  = 14'b00000000000100,
        S_POW    = 14'b00000000001000,  // run exponentiation, sub-step chosen below
        S_POWW   = 14'b00000000010000,
        S_EULER  = 14'b00000000100000,
        S_ZTEST  = 14'b00000001000000,
        S_SETUP  = 14'b00000010000000,
        S_LOOP   = 14'b00000100000000,
        S_ORD    = 14'b00001000000000,
        S_ORDW   = 14'b00010000000000,
        S_MULW   = 14'b00100000000000,
        S_FIX    = 14'b01000000000000,
        S_OUT    = 14'b10000000000000
    } state_t;

    // what an exponentiation result feeds
    typedef enum logic [2:0] {
        P_EULER = 3'd0,
        P_ZTEST = 3'd1,
        P_C     = 3'd2,
        P_U     = 3'd3,
        P_R     = 3'd4
    } pow_dst_t;

    // correction sub-steps
    typedef enum logic [2:0] {
        F_SQB  = 3'd0,
        F_R    = 3'd1,
        F_BB   = 3'd2,
        F_U    = 3'd3,
        F_DONE = 3'd4
    } fix_t;

    state_t           state_reg, state_next;
    pow_dst_t         dst_reg, dst_next;
    fix_t             fix_reg, fix_next;
    logic [WIDTH-1:0] p_reg, p_next;
    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] q_reg, q_next;
    logic [SW-1:0]    s_reg, s_next;
    logic [WIDTH-1:0] z_reg, z_next;
    logic [NW-1:0]    nz_reg, nz_next;
    logic [WIDTH-1:0] c_reg, c_next;
    logic [WIDTH-1:0] u_reg, u_next;
    logic [WIDTH-1:0] r_reg, r_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [WIDTH-1:0] bb_reg, bb_next;
    logic [SW-1:0]    i_reg, i_next;
    logic [SW-1:0]    k_reg, k_next;
    logic [SW-1:0]    it_reg, it_next;
    // exponentiation registers: base, running result, exponent shift
    logic [WIDTH-1:0] pb_reg, pb_next;
    logic [WIDTH-1:0] pr_reg, pr_next;
    logic [WIDTH-1:0] pe_reg, pe_next;
    logic             pph_reg, pph_next;  // 0: multiply result, 1: square base
    logic [31:0]      root_reg, root_next;
    logic             nr_reg, nr_next;
    logic             ov_reg, ov_next;

    mul_ctl_t         mctl, dctl;
    mul_sts_t         msts, dsts;
    logic [WIDTH-1:0] ma, mb, prod, rem;
    logic [WIDTH-1:0] one_w;
    logic [WIDTH-1:0] pm1;
    logic [WIDTH-1:0] v_in, p_in;

    assign one_w = WIDTH'(1);
    assign pm1   = p_reg - one_w;
    assign v_in  = WIDTH'(value);
    assign p_in  = WIDTH'(prime_modulus);

    msr_mulmod #(.WIDTH(WIDTH)) u_mul (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (mctl),
        .sts  (msts),
        .a    (ma),
        .b    (mb),
        .m    (p_reg),
        .prod (prod)
    );

    msr_divmod #(.WIDTH(WIDTH)) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (dctl),
        .sts  (dsts),
        .num  (a_reg),
        .m    (p_reg),
        .rem  (rem)
    );

    always_comb
    begin
        state_next = state_reg;
        dst_next   = dst_reg;
        fix_next   = fix_reg;
        p_next     = p_reg;
        a_next     = a_reg;
        q_next     = q_reg;
        s_next     = s_reg;
        z_next     = z_reg;
        nz_next    = nz_reg;
        c_next     = c_reg;
        u_next     = u_reg;
        r_next     = r_reg;
        b_next     = b_reg;
        bb_next    = bb_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        it_next    = it_reg;
        pb_next    = pb_reg;
        pr_next    = pr_reg;
        pe_next    = pe_reg;
        pph_next   = pph_reg;
        root_next  = root_reg;
        nr_next    = nr_reg;
        ov_next    = ov_reg;
        mctl.start = 1'b0;
        dctl.start = 1'b0;
        ma         = pr_reg;
        mb         = pb_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    a_next     = v_in;
                    p_next     = p_in;
                    state_next = S_RED;
                    ov_next    = 1'b0;
                end
            end
            S_RED:
            begin
                // p of 0 or 1: answer 0 at once
                if (p_reg < WIDTH'(2))
                begin
                    root_next  = '0;
                    nr_next    = 1'b0;
                    state_next = S_OUT;
                end
                else
                begin
                    dctl.start = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (dsts.done)
                begin
                    a_next = rem;
                    // strip powers of two from p-1, one bit per cycle below
                    q_next = pm1;
                    s_next = '0;
                    if (p_reg == WIDTH'(2) || rem == '0)
                    begin
                        root_next  = 32'(rem);
                        nr_next    = 1'b0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        pb_next    = rem;
                        pr_next    = one_w;
                        pe_next    = pm1 >> 1;
                        pph_next   = 1'b0;
                        dst_next   = P_EULER;
                        state_next = S_POW;
                    end
                end
            end
            S_POW:
            begin
                // square-and-multiply, exponent LSB first
                if (pe_reg == '0)
                begin
                    unique case (dst_reg)
                        P_EULER: state_next = S_EULER;
                        P_ZTEST: state_next = S_ZTEST;
                        P_C:
                        begin
                            c_next     = pr_reg;
                            pb_next    = a_reg;
                            pr_next    = one_w;
                            pe_next    = q_reg;
                            dst_next   = P_U;
                        end
                        P_U:
                        begin
                            u_next     = pr_reg;
                            pb_next    = a_reg;
                            pr_next    = one_w;
                            pe_next    = (q_reg >> 1) + one_w;
                            dst_next   = P_R;
                        end
                        P_R:
                        begin
                            r_next     = pr_reg;
                            it_next    = '0;
                            state_next = S_LOOP;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
                else if (!pph_reg && !pe_reg[0])
                    pph_next = 1'b1;
                else
                begin
                    ma         = pph_reg ? pb_reg : pr_reg;
                    mb         = pb_reg;
                    mctl.start = 1'b1;
                    state_next = S_POWW;
                end
            end
            S_POWW:
            begin
                ma = pph_reg ? pb_reg : pr_reg;
                mb = pb_reg;
                if (msts.done)
                begin
                    if (pph_reg)
                    begin
                        pb_next  = prod;
                        pe_next  = pe_reg >> 1;
                        pph_next = 1'b0;
                    end
                    else
                    begin
                        pr_next  = prod;
                        pph_next = 1'b1;
                    end
                    state_next = S_POW;
                end
            end
            S_EULER:
            begin
                // also finish factoring p-1 before starting the non-residue search
                if (pr_reg == pm1)
                begin
                    root_next  = '0;
                    nr_next    = 1'b1;
                    state_next = S_OUT;
                end
                else if (!q_reg[0])
                begin
                    q_next = q_reg >> 1;
                    s_next = s_reg + 1'b1;
                end
                else
                begin
                    z_next     = WIDTH'(2);
                    nz_next    = '0;
                    state_next = S_ZTEST;
                    dst_next   = P_ZTEST;
                    // start first candidate test
                    pb_next    = WIDTH'(2);
                    pr_next    = one_w;
                    pe_next    = pm1 >> 1;
                    pph_next   = 1'b0;
                    ov_next    = 1'b1;  // marks that a test is pending
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                // launch a candidate test unless the search is exhausted
                if (z_reg >= p_reg || nz_reg == NW'(NR_LIMIT))
                begin
                    root_next  = '0;
                    nr_next    = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    pb_next    = z_reg;
                    pr_next    = one_w;
                    pe_next    = pm1 >> 1;
                    pph_next   = 1'b0;
                    dst_next   = P_ZTEST;
                    state_next = S_POW;
                end
            end
            S_ZTEST:
            begin
                if (pr_reg != one_w)
                begin
                    pb_next    = z_reg;
                    pr_next    = one_w;
                    pe_next    = q_reg;
                    pph_next   = 1'b0;
                    dst_next   = P_C;
                    state_next = S_POW;
                end
                else
                begin
                    z_next     = z_reg + one_w;
                    nz_next    = nz_reg + 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_LOOP:
            begin
                if (u_reg == one_w)
                begin
                    root_next  = 32'(r_reg);
                    nr_next    = 1'b0;
                    state_next = S_OUT;
                end
                else if (it_reg >= s_reg)
                begin
                    root_next  = '0;
                    nr_next    = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    b_next     = u_reg;
                    i_next     = '0;
                    state_next = S_ORD;
                end
            end
            S_ORD:
            begin
                // find least i with u^(2^i) == 1
                if (b_reg == one_w)
                begin
                    b_next     = c_reg;
                    k_next     = '0;
                    fix_next   = F_SQB;
                    state_next = S_FIX;
                end
                else
                begin
                    ma         = b_reg;
                    mb         = b_reg;
                    mctl.start = 1'b1;
                    state_next = S_ORDW;
                end
            end
            S_ORDW:
            begin
                ma = b_reg;
                mb = b_reg;
                if (msts.done)
                begin
                    b_next = prod;
                    i_next = i_reg + 1'b1;
                    if (i_reg + 1'b1 >= s_reg)
                    begin
                        root_next  = '0;
                        nr_next    = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_ORD;
                end
            end
            S_FIX:
            begin
                unique case (fix_reg)
                    F_SQB:
                    begin
                        if ({1'b0, k_reg} + {1'b0, i_reg} + 1 < {1'b0, s_reg})
                        begin
                            ma = b_reg;
                            mb = b_reg;
                            mctl.start = 1'b1;
                            state_next = S_MULW;
                        end
                        else
                            fix_next = F_R;
                    end
                    F_R:
                    begin
                        ma = r_reg;
                        mb = b_reg;
                        mctl.start = 1'b1;
                        state_next = S_MULW;
                    end
                    F_BB:
                    begin
                        ma = b_reg;
                        mb = b_reg;
                        mctl.start = 1'b1;
                        state_next = S_MULW;
                    end
                    F_U:
                    begin
                        ma = u_reg;
                        mb = bb_reg;
                        mctl.start = 1'b1;
                        state_next = S_MULW;
                    end
                    F_DONE:
                    begin
                        it_next    = it_reg + 1'b1;
                        state_next = S_LOOP;
                    end
                    default: state_next = S_LOOP;
                endcase
            end
            S_MULW:
            begin
                case (fix_reg)
                    F_R:     begin ma = r_reg; mb = b_reg;  end
                    F_U:     begin ma = u_reg; mb = bb_reg; end
                    default: begin ma = b_reg; mb = b_reg;  end
                endcase
                if (msts.done)
                begin
                    state_next = S_FIX;
                    case (fix_reg)
                        F_SQB:
                        begin
                            b_next = prod;
                            k_next = k_reg + 1'b1;
                        end
                        F_R:
                        begin
                            r_next   = prod;
                            fix_next = F_BB;
                        end
                        F_BB:
                        begin
                            bb_next  = prod;
                            fix_next = F_U;
                        end
                        F_U:
                        begin
                            u_next   = prod;
                            fix_next = F_DONE;
                        end
                        default: fix_next = F_DONE;
                    endcase
                end
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dst_reg   <= P_EULER;
            fix_reg   <= F_SQB;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dst_reg   <= dst_next;
            fix_reg   <= fix_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        a_reg    <= a_next;
        q_reg    <= q_next;
        s_reg    <= s_next;
        z_reg    <= z_next;
        nz_reg   <= nz_next;
        c_reg    <= c_next;
        u_reg    <= u_next;
        r_reg    <= r_next;
        b_reg    <= b_next;
        bb_reg   <= bb_next;
        i_reg    <= i_next;
        k_reg    <= k_next;
        it_reg   <= it_next;
        pb_reg   <= pb_next;
        pr_reg   <= pr_next;
        pe_reg   <= pe_next;
        pph_reg  <= pph_next;
        root_reg <= root_next;
        nr_reg   <= nr_next;
    end

    assign in_ready  = (state_reg == S_IDLE) && !ov_reg ? 1'b1 : (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign root      = root_reg;
    assign no_root   = nr_reg;

    // hold the result stable while waiting on the consumer
    `MSR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(root))
    // multiplier is never restarted while busy
    `MSR_ASSERT_IMPL(a_mul_start, mctl.start, !msts.busy)
    // no result flagged with a nonzero root
    `MSR_ASSERT_IMPL(a_nr_zero, out_valid && no_root, root == 32'd0)
endmodule
`default_nettype wire

@@ tb/modular_square_root_tb.sv @@
// ---------------------------------------------------------------------------
// modular_square_root_tb
// Drives value/prime pairs into the Tonelli-Shanks block and checks each root.
// ---------------------------------------------------------------------------
// A queue of pending requests feeds a falling-edge driver. A rising-edge
// monitor checks every result against a software square-root calculator
// that runs in step with the driver. The random part uses mostly random
// 32-bit primes, found with a Miller-Rabin test, and perfect squares.
// Both sides go through phases of no idling, heavy sender gaps, heavy
// receiver stalls, and a mix of the two.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module modular_square_root_tb;
    import msr_pkg::*;

    localparam int IDLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct {
        logic [31:0] value;
        logic [31:0] modulus;
    } sqrt_req_t;

    typedef struct {
        logic [31:0] root;
        logic        no_root;
    } sqrt_res_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] value;
    logic [31:0] prime_modulus;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] root;
    logic        no_root;

    sqrt_req_t   pending_reqs[$];
    sqrt_res_t   expected_roots[$];
    logic        in_taken;
    int          mismatches;
    int          results_seen;
    int          idle_cycles;
    int          phase;  // 0 none, 1 sender idles, 2 receiver stalls, 3 both
    int          total_items;
    int          items_sent;

    modular_square_root u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .value        (value),
        .prime_modulus(prime_modulus),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .root         (root),
        .no_root      (no_root)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // -----------------------------------------------------------------------
    // Modular arithmetic; operands stay below 2^32, so products fit 64 bits.
    // -----------------------------------------------------------------------
    function automatic longint unsigned mulm(longint unsigned a, longint unsigned b,
                                             longint unsigned m);
        return (a * b) % m;
    endfunction

    function automatic longint unsigned powm(longint unsigned b, longint unsigned e,
                                             longint unsigned m);
        longint unsigned r;
        r = 1;
        while (e != 0)
        begin
            if (e[0])
                r = mulm(r, b, m);
            b = mulm(b, b, m);
            e = e >> 1;
        end
        return r;
    endfunction

    // Square root calculator, including the bounded searches that make a
    // composite modulus give up with no_root.
    function automatic sqrt_res_t calc_sqrt(sqrt_req_t rq);
        sqrt_res_t       res;
        longint unsigned p, a, e, q, z, c, u, r, b;
        int              s, i, iter, k;
        bit              found;
        res.root = '0;
        res.no_root = 1'b0;
        p = rq.modulus;
        if (p < 2)
            return res;
        a = rq.value % p;
        if (p == 2 || a == 0)
        begin
            res.root = a[31:0];
            return res;
        end
        res.no_root = 1'b1;
        e = (p - 1) >> 1;
        if (powm(a, e, p) == p - 1)
            return res;
        q = p - 1;
        s = 0;
        while (q[0] == 1'b0)
        begin
            q = q >> 1;
            s++;
        end
        found = 1'b0;
        for (z = 2; z < p && z < 2 + NR_LIMIT; z++)
        begin
            if (powm(z, e, p) != 1)
            begin
                found = 1'b1;
                break;
            end
        end
        if (!found)
            return res;
        c = powm(z, q, p);
        u = powm(a, q, p);
        r = powm(a, (q >> 1) + 1, p);
        iter = 0;
        while (u != 1)
        begin
            if (iter >= s)
                return res;
            i = 0;
            b = u;
            while (b != 1)
            begin
                b = mulm(b, b, p);
                i++;
                if (i >= s)
                    return res;
            end
            b = c;
            for (k = 0; k + i + 1 < s; k++)
                b = mulm(b, b, p);
            r = mulm(r, b, p);
            u = mulm(u, mulm(b, b, p), p);
            iter++;
        end
        res.root = r[31:0];
        res.no_root = 1'b0;
        return res;
    endfunction

    // Miller-Rabin with bases 2, 7 and 61 is exact below 2^32.
    function automatic bit is_prime(longint unsigned n);
        longint unsigned d, x;
        longint unsigned bases[3];
        int              s, j;
        bit              hit;
        bases = '{2, 7, 61};
        if (n < 2)
            return 1'b0;
        foreach (bases[t])
            if (n == bases[t])
                return 1'b1;
        if (n[0] == 1'b0)
            return 1'b0;
        d = n - 1;
        s = 0;
        while (d[0] == 1'b0)
        begin
            d = d >> 1;
            s++;
        end
        foreach (bases[t])
        begin
            if (bases[t] % n == 0)
                continue;
            x = powm(bases[t] % n, d, n);
            if (x == 1 || x == n - 1)
                continue;
            hit = 1'b0;
            for (j = 1; j < s; j++)
            begin
                x = mulm(x, x, n);
                if (x == n - 1)
                begin
                    hit = 1'b1;
                    break;
                end
            end
            if (!hit)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [31:0] random_prime(bit small_only);
        logic [31:0] n;
        do
        begin
            if (small_only)
                n = $urandom_range(1000, 3);
            else
                n = $urandom | 32'h1;
        end
        while (!is_prime(n));
        return n;
    endfunction

    task automatic add_req(logic [31:0] v, logic [31:0] m);
        sqrt_req_t rq;
        rq.value = v;
        rq.modulus = m;
        pending_reqs.push_back(rq);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch on result %0d: %s got %0h expected %0h",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    // -----------------------------------------------------------------------
    // Driver: present the next request at the falling edge once the current
    // transaction has gone through; hold valid and payload until then.
    // -----------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            out_ready <= 1'b0;
        end
        else
        begin
            if (!in_valid || in_taken)
            begin
                if (pending_reqs.size() != 0 &&
                    !((phase == 1 && $urandom_range(99) < 71) ||
                      (phase == 3 && $urandom_range(99) < 14)))
                begin
                    sqrt_req_t rq;
                    rq = pending_reqs.pop_front();
                    value <= rq.value;
                    prime_modulus <= rq.modulus;
                    in_valid <= 1'b1;
                    expected_roots.push_back(calc_sqrt(rq));
                    items_sent++;
                    phase <= (items_sent * 4) / (total_items + 1);
                end
                else
                    in_valid <= 1'b0;
            end
            // Stall the receiver according to the phase.
            if (phase == 2)
                out_ready <= ($urandom_range(99) >= 71);
            else if (phase == 3)
                out_ready <= ($urandom_range(99) >= 14);
            else
                out_ready <= 1'b1;
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: sample at the rising edge, compare with the oldest expectation.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        in_taken <= in_valid && in_ready;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
            if (out_valid && out_ready)
            begin
                if (expected_roots.size() == 0)
                    report_mismatch("unexpected root", root, 32'd0);
                else
                begin
                    sqrt_res_t want;
                    want = expected_roots.pop_front();
                    if (root !== want.root)
                        report_mismatch("root", root, want.root);
                    if (no_root !== want.no_root)
                        report_mismatch("no_root", {31'b0, no_root}, {31'b0, want.no_root});
                end
                results_seen++;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus and end of run.
    // -----------------------------------------------------------------------
    initial
    begin
        logic [31:0] p, x;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        value = '0;
        prime_modulus = '0;
        in_taken = 1'b0;
        mismatches = 0;
        results_seen = 0;
        idle_cycles = 0;
        phase = 0;
        items_sent = 0;

        // Directed: degenerate moduli, modulus 2, zero residue, extremes,
        // non-residues, a large two-adic prime, small composites.
        add_req(32'd5, 32'd0);
        add_req(32'hFFFFFFFF, 32'd1);
        add_req(32'd7, 32'd2);
        add_req(32'hFFFFFFFE, 32'd2);
        add_req(32'd0, 32'd3);
        add_req(32'd1, 32'd3);
        add_req(32'd2, 32'd3);
        add_req(32'd26, 32'd13);
        add_req(32'd10, 32'd13);
        add_req(32'd5, 32'd13);
        add_req(32'hFFFFFFFF, 32'hFFFFFFFB);
        add_req(32'hFFFFFFFA, 32'hFFFFFFFB);
        add_req(32'd3, 32'hFFFFFFFB);
        add_req(32'd0, 32'hFFFFFFFB);
        add_req(32'd2, 32'd3221225473);
        add_req(32'd5, 32'd3221225473);
        add_req(32'd7, 32'd17);
        add_req(32'd3, 32'd9);
        add_req(32'd7, 32'd15);
        add_req(32'd2, 32'd4);
        add_req(32'd3, 32'd4);
        add_req(32'hAAAAAAAA, 32'd65537);

        // Random: mostly big primes, half with perfect squares.
        repeat (80)
        begin
            case ($urandom_range(9))
                0: p = random_prime(1'b1);
                1: p = $urandom_range(1000, 2);  // small modulus, may be composite
                default: p = random_prime(1'b0);
            endcase
            if ($urandom_range(1))
            begin
                x = $urandom % p;
                add_req(32'(mulm(x, x, p) + (($urandom_range(1)) ? 64'(p) : 64'd0)), p);
            end
            else
                add_req($urandom, p);
        end
        total_items = pending_reqs.size();

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        while (pending_reqs.size() != 0 || in_valid || expected_roots.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d results over %0d requests through four flow-control phases",
                 results_seen, total_items);
        if (mismatches == 0 && expected_roots.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
